// File: hdl/crcpe_pkg.sv
// crcpe_pkg: shared types and constants of the programmable crc encoder/checker
// no dependencies; used by crcpe_front, crcpe_queue, crcpe_back and the top level

package crcpe_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_DEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHK_MODE = 2'd2;

  localparam int GEN_LOW_W = 32;
  localparam int GEN_DEG_W = 6;
  localparam logic [GEN_LOW_W-1:0] GEN_LOW_RST = 32'h04C1_1DB7;
  localparam logic [GEN_DEG_W-1:0] GEN_DEG_RST = 6'd32;

  // job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_ECHO      = 2'd0,  // plain echo of a message bit
    JOB_ECHO_TAIL = 2'd1,  // echo of the final bit, remainder tail follows
    JOB_VERDICT   = 2'd2   // check result at the final bit
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic      data_bit;  // message bit for echoes, pass flag for a verdict
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

// File: hdl/crcpe_queue.sv
// crcpe_queue: small register queue of jobs between front and back
// depends on crcpe_pkg for depth constants

module crcpe_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [crcpe_pkg::Q_DEPTH];
  logic [crcpe_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [crcpe_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [crcpe_pkg::Q_CW-1:0] count_r, count_nxt;

  assign full = (count_r == crcpe_pkg::Q_CW'(crcpe_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/crcpe_front.sv
// crcpe_front: accepts message bits, runs the remainder register, classifies jobs
// depends on crcpe_pkg for job types and register widths

module crcpe_front #(
  parameter int MAX_DEGREE = 32,
  parameter int DW = 6,
  parameter int QW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              msg_bit,
  input  logic                              fin_bit,
  input  logic [crcpe_pkg::GEN_LOW_W-1:0]   gen_low,
  input  logic [crcpe_pkg::GEN_DEG_W-1:0]   gen_deg,
  input  logic                              chk_mode,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [QW-1:0]                     q_data
);

  logic [MAX_DEGREE-1:0] rem_r, rem_nxt;
  logic [MAX_DEGREE-1:0] ones, mask, poly, rem_m, shifted, div_res;
  logic [DW-1:0]         deg_eff;
  logic                  top, accept, fb;
  crcpe_pkg::job_ctl_t   ctl;

  // effective degree: zero counts as one, capped at MAX_DEGREE
  always_comb begin
    if (gen_deg == '0) begin
      deg_eff = DW'(1);
    end else if (32'(gen_deg) > 32'(MAX_DEGREE)) begin
      deg_eff = DW'(MAX_DEGREE);
    end else begin
      deg_eff = DW'(gen_deg);
    end
  end

  assign ones = '1;
  assign mask = ones >> (DW'(MAX_DEGREE) - deg_eff);
  assign poly = MAX_DEGREE'(gen_low) & mask;
  assign rem_m = rem_r & mask;
  // bit d-1 is the highest bit of the mask
  assign top = |(rem_m & (mask ^ (mask >> 1)));
  assign shifted = rem_m << 1;

  always_comb begin
    if (chk_mode) begin
      fb = top;
      div_res = (shifted | MAX_DEGREE'(msg_bit)) & mask;
    end else begin
      fb = top ^ msg_bit;
      div_res = shifted & mask;
    end
  end

  assign rem_nxt = div_res ^ ({MAX_DEGREE{fb}} & poly);

  assign in_ready = !q_full;
  assign accept = in_valid && !q_full;

  always_comb begin
    ctl.data_bit = msg_bit;
    if (chk_mode) begin
      ctl.kind = crcpe_pkg::JOB_VERDICT;
      ctl.data_bit = (rem_nxt == '0);
    end else if (fin_bit) begin
      ctl.kind = crcpe_pkg::JOB_ECHO_TAIL;
    end else begin
      ctl.kind = crcpe_pkg::JOB_ECHO;
    end
  end

  // check mode only reports at the final bit
  assign q_push = accept && (!chk_mode || fin_bit);
  assign q_data = {rem_nxt, deg_eff, ctl};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (accept) begin
      rem_r <= fin_bit ? '0 : rem_nxt;
    end
  end

endmodule

// File: hdl/crcpe_back.sv
// crcpe_back: turns queued jobs into result transfers, shifts out remainder tails
// depends on crcpe_pkg for job types

module crcpe_back #(
  parameter int MAX_DEGREE = 32,
  parameter int DW = 6,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          code_bit,
  output logic          is_verdict,
  output logic          check_passed,
  output logic          end_of_run
);

  logic [MAX_DEGREE-1:0] job_rem;
  logic [DW-1:0]         job_deg;
  crcpe_pkg::job_ctl_t   job_ctl;

  logic [MAX_DEGREE-1:0] tail_r, tail_nxt;
  logic [DW-1:0]         tail_cnt_r, tail_cnt_nxt;
  logic                  valid_r, valid_nxt;
  logic                  code_r, code_nxt;
  logic                  verd_r, verd_nxt;
  logic                  pass_r, pass_nxt;
  logic                  last_r, last_nxt;
  logic                  load_ok;

  assign {job_rem, job_deg, job_ctl} = q_data;

  assign load_ok = !valid_r || out_ready;
  assign q_pop = load_ok && (tail_cnt_r == '0) && !q_empty;

  always_comb begin
    tail_nxt = tail_r;
    tail_cnt_nxt = tail_cnt_r;
    valid_nxt = valid_r;
    code_nxt = code_r;
    verd_nxt = verd_r;
    pass_nxt = pass_r;
    last_nxt = last_r;
    if (load_ok) begin
      valid_nxt = 1'b0;
      if (tail_cnt_r != '0) begin
        // remainder tail, most significant bit first
        valid_nxt = 1'b1;
        code_nxt = tail_r[MAX_DEGREE-1];
        verd_nxt = 1'b0;
        pass_nxt = 1'b0;
        last_nxt = (tail_cnt_r == DW'(1));
        tail_nxt = tail_r << 1;
        tail_cnt_nxt = tail_cnt_r - 1'b1;
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        unique case (job_ctl.kind)
          crcpe_pkg::JOB_ECHO: begin
            code_nxt = job_ctl.data_bit;
            verd_nxt = 1'b0;
            pass_nxt = 1'b0;
            last_nxt = 1'b0;
          end
          crcpe_pkg::JOB_ECHO_TAIL: begin
            code_nxt = job_ctl.data_bit;
            verd_nxt = 1'b0;
            pass_nxt = 1'b0;
            last_nxt = 1'b0;
            // left-align so the top remainder bit leaves first
            tail_nxt = job_rem << (DW'(MAX_DEGREE) - job_deg);
            tail_cnt_nxt = job_deg;
          end
          crcpe_pkg::JOB_VERDICT: begin
            code_nxt = 1'b0;
            verd_nxt = 1'b1;
            pass_nxt = job_ctl.data_bit;
            last_nxt = 1'b1;
          end
          default: begin
            valid_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tail_cnt_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      tail_cnt_r <= tail_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    code_r <= code_nxt;
    verd_r <= verd_nxt;
    pass_r <= pass_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign code_bit = code_r;
  assign is_verdict = verd_r;
  assign check_passed = pass_r;
  assign end_of_run = last_r;

endmodule

// File: hdl/programmable_crc_encode_check.sv
// programmable_crc_encode_check: top level of the bit-serial programmable crc
// depends on crcpe_pkg, crcpe_front, crcpe_queue and crcpe_back
//
// channel   dir  handshake          payload
// in_       in   tvalid/tready      tdata[0] message_bit, tlast final_bit
// out_      out  tvalid/tready      tdata[0] code_bit, tdata[1] check_passed,
//                                   tuser is_verdict, tlast end_of_run
// cfg_      in   we (no ready)      index selects register, wdata up to 32 bits
//
// one input transfer per cycle while the job queue is not full; the remainder register in the front updates
// once per accepted bit
// encode: one result per bit, the final bit adds D tail results shifted out
// of the back's tail register, one per cycle while out_tready is high
// the input keeps flowing during a tail until the 4-entry job queue fills
// synchronous active-low reset; no memory, so no clearing pass is needed
// out_tvalid is registered and holds under backpressure

module programmable_crc_encode_check #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] message_bit, [7:1] zero
  input  logic                                in_tlast,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [0] code_bit, [1] check_passed
  output logic                                out_tuser,  // [0] is_verdict
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [crcpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crcpe_pkg::GEN_LOW_W-1:0]     cfg_wdata
);

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int QW = MAX_DEGREE + DW + crcpe_pkg::JOB_CTL_W;

  // configuration registers
  logic [crcpe_pkg::GEN_LOW_W-1:0] gen_low_r;
  logic [crcpe_pkg::GEN_DEG_W-1:0] gen_deg_r;
  logic                            chk_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_low_r <= crcpe_pkg::GEN_LOW_RST;
      gen_deg_r <= crcpe_pkg::GEN_DEG_RST;
      chk_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crcpe_pkg::REG_GEN_LOW:  gen_low_r <= cfg_wdata;
        crcpe_pkg::REG_GEN_DEG:  gen_deg_r <= cfg_wdata[crcpe_pkg::GEN_DEG_W-1:0];
        crcpe_pkg::REG_CHK_MODE: chk_mode_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // front to queue
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_head;

  crcpe_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .DW         (DW),
    .QW         (QW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .msg_bit  (in_tdata[0]),
    .fin_bit  (in_tlast),
    .gen_low  (gen_low_r),
    .gen_deg  (gen_deg_r),
    .chk_mode (chk_mode_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  crcpe_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty)
  );

  logic code_bit, is_verdict, check_passed, end_of_run;

  crcpe_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .DW         (DW),
    .QW         (QW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .code_bit     (code_bit),
    .is_verdict   (is_verdict),
    .check_passed (check_passed),
    .end_of_run   (end_of_run)
  );

  assign out_tdata = {6'b0, check_passed, code_bit};
  assign out_tuser = is_verdict;
  assign out_tlast = end_of_run;

  // a verdict always closes its run and carries no code bit
  a_verdict_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && !out_tdata[0])
    else $error("verdict transfer without end of run or with a code bit");

  // encode results never claim a passed check
  a_no_pass_in_encode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[1])
    else $error("check_passed set on an encode transfer");

  // nothing is presented right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid directly after reset");

  // the queue accepts nothing when it reports full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push && !in_tready)
    else $error("job pushed into a full queue");

endmodule
